>>> rtl/vpa_pkg.sv
// shared types, constants and codes of the variable partition allocator
package vpa_pkg;

  localparam int MEM_UNITS  = 256;
  localparam int MAX_PARTS  = 64;
  localparam int OWNER_BITS = 8;

  localparam int IDX_W  = $clog2(MAX_PARTS);
  localparam int CNT_W  = $clog2(MAX_PARTS + 1);
  localparam int SIZE_W = 9;
  localparam int ADDR_W = 8;

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // fit policy
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // register indexes
  localparam logic REG_FIT_MODE    = 1'b0;
  localparam logic REG_TOTAL_UNITS = 1'b1;

  // cell commands
  localparam logic [2:0] CMD_HOLD  = 3'd0;
  localparam logic [2:0] CMD_ROT   = 3'd1;
  localparam logic [2:0] CMD_INIT  = 3'd2;
  localparam logic [2:0] CMD_GRANT = 3'd3;
  localparam logic [2:0] CMD_SPLIT = 3'd4;
  localparam logic [2:0] CMD_MERGE = 3'd5;

  typedef struct packed {
    logic [ADDR_W-1:0]     start;
    logic [SIZE_W-1:0]     size;
    logic [OWNER_BITS-1:0] owner;
  } row_t;

  typedef struct packed {
    logic [2:0]            cmd;
    logic [IDX_W-1:0]      sel;
    logic [OWNER_BITS-1:0] grant_owner;
    logic [SIZE_W-1:0]     grant_size;
    row_t                  wr_row;
  } cell_ctl_t;

  typedef struct packed {
    logic                  op;
    logic [OWNER_BITS-1:0] owner_id;
    logic [SIZE_W-1:0]     request_size;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] start_address;
    logic [SIZE_W-1:0] freed_units;
  } out_t;

endpackage

>>> rtl/vpa_cell.sv
// one row of the partition table with its neighbor hand-off
module vpa_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [vpa_pkg::IDX_W-1:0] idx,
  input  vpa_pkg::cell_ctl_t      ctl,
  input  vpa_pkg::row_t           left,
  input  vpa_pkg::row_t           right,
  output vpa_pkg::row_t           row,
  output logic                    can_merge
);
  import vpa_pkg::*;

  row_t row_next;
  logic [IDX_W:0] idx_x;
  logic [IDX_W:0] sel_x;
  logic [IDX_W:0] sel_p1;

  assign idx_x  = {1'b0, idx};
  assign sel_x  = {1'b0, ctl.sel};
  assign sel_p1 = sel_x + (IDX_W+1)'(1);

  assign can_merge = (idx == ctl.sel) && (row.owner == '0) && (right.owner == '0);

  always_comb begin
    row_next = row;
    case (ctl.cmd)
      CMD_ROT: row_next = right;
      CMD_INIT: begin
        if (idx == '0) row_next = ctl.wr_row;
      end
      CMD_GRANT: begin
        if (idx == ctl.sel) begin
          row_next.owner = ctl.grant_owner;
          row_next.size  = ctl.grant_size;
        end
      end
      CMD_SPLIT: begin
        if (idx_x == sel_x) begin
          row_next.owner = ctl.grant_owner;
          row_next.size  = ctl.grant_size;
        end else if (idx_x == sel_p1) begin
          row_next = ctl.wr_row;
        end else if (idx_x > sel_p1) begin
          row_next = left;
        end
      end
      CMD_MERGE: begin
        if (idx == ctl.sel) begin
          row_next.size = row.size + right.size;
        end else if (idx > ctl.sel) begin
          row_next = right;
        end
      end
      default: row_next = row;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      if (idx == '0) begin
        row.start <= '0;
        row.size  <= SIZE_W'(MEM_UNITS);
        row.owner <= '0;
      end
    end else begin
      row <= row_next;
    end
  end

endmodule

>>> rtl/variable_partition_allocator_unit.sv
// top level of the variable partition allocator: control sequencer and row chain
//
// The partition table lives in a chain of MAX_PARTS row cells, row i in cell i.
// An allocate transaction rotates the whole chain once so every row passes
// cell 0, where the first, best or worst fit is chosen; the apply state then
// grants the row and, when a remainder is left, inserts a free row behind it
// by shifting the upper cells one place up (a full table refuses the split).
// A free transaction rotates the chain once to release the owner's rows and
// add up their sizes, then sweeps the rows from the bottom, folding each pair
// of adjacent free rows into one per cycle by shifting the upper cells down.
// Rejected requests (owner 0, or a zero-size allocate) go straight to the
// result. One transaction is worked on at a time; a finished result sits in
// an output register, so a new request is taken while the result still
// waits, and a second finished result waits in place until that register
// drains. A write of total_units resets the table to one free row;
// configuration is taken only while the block is idle.
module variable_partition_allocator_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  vpa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output vpa_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [8:0]    cfg_data
);
  import vpa_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_MERGE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;      // rows in use
  logic [1:0]        fit_mode;
  logic [CNT_W-1:0]  step;       // rotation step, also index of the row at the head
  logic [IDX_W-1:0]  k;          // merge sweep position
  logic              found;
  logic [IDX_W-1:0]  pick;
  logic [SIZE_W-1:0] pick_size;
  logic [ADDR_W-1:0] pick_start;
  logic [SIZE_W-1:0] sum;
  in_t               req;
  out_t              res;

  row_t              rows [MAX_PARTS];
  logic [MAX_PARTS-1:0] merge_flags;
  row_t              head;
  row_t              feed;
  cell_ctl_t         ctl;

  logic              in_acc;
  logic              cfg_acc;
  logic              out_free;
  logic              head_live;   // head row is inside the table
  logic              fits;
  logic              better;
  logic              owner_hit;
  logic [CNT_W-1:0]  k_p1;
  logic              merge_go;
  logic [SIZE_W-1:0] leftover;
  logic [SIZE_W-1:0] split_start;
  logic [SIZE_W-1:0] units;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;

  assign head      = rows[0];
  assign head_live = (step < count);
  assign fits      = head_live && (head.owner == '0) && (head.size >= req.request_size);
  assign better    = ((fit_mode == FIT_BEST)  && (head.size < pick_size)) ||
                     ((fit_mode == FIT_WORST) && (head.size > pick_size));
  assign owner_hit = head_live && (head.owner == req.owner_id);

  // the head row re-enters at the top; a free clears the owner on the way
  always_comb begin
    feed = head;
    if (state == S_FREE && owner_hit) feed.owner = '0;
  end

  assign k_p1     = CNT_W'(k) + CNT_W'(1);
  assign merge_go = (k_p1 < count) && (|merge_flags);

  assign leftover    = pick_size - req.request_size;
  assign split_start = SIZE_W'(pick_start) + req.request_size;

  // clamp of the size register
  always_comb begin
    if (cfg_data == '0) units = SIZE_W'(1);
    else if (cfg_data > SIZE_W'(MEM_UNITS)) units = SIZE_W'(MEM_UNITS);
    else units = cfg_data;
  end

  // command broadcast to the chain
  always_comb begin
    ctl             = '0;
    ctl.cmd         = CMD_HOLD;
    ctl.grant_owner = req.owner_id;
    ctl.grant_size  = req.request_size;
    ctl.sel         = pick;
    ctl.wr_row.start = split_start[ADDR_W-1:0];
    ctl.wr_row.size  = leftover;
    ctl.wr_row.owner = '0;
    case (state)
      S_IDLE: begin
        if (cfg_acc && cfg_index == REG_TOTAL_UNITS) begin
          ctl.cmd          = CMD_INIT;
          ctl.wr_row.start = '0;
          ctl.wr_row.size  = units;
          ctl.wr_row.owner = '0;
        end
      end
      S_SCAN, S_FREE: ctl.cmd = CMD_ROT;
      S_APPLY: begin
        if (found) begin
          if (leftover == '0) ctl.cmd = CMD_GRANT;
          else if (count < CNT_W'(MAX_PARTS)) ctl.cmd = CMD_SPLIT;
        end
      end
      S_MERGE: begin
        ctl.sel = k;
        if (merge_go) ctl.cmd = CMD_MERGE;
      end
      default: ctl.cmd = CMD_HOLD;
    endcase
  end

  // row chain
  for (genvar g = 0; g < MAX_PARTS; g++) begin : g_cell
    row_t left_row;
    row_t right_row;
    if (g == 0) begin : g_first
      assign left_row = '0;
    end else begin : g_mid_l
      assign left_row = rows[g-1];
    end
    if (g == MAX_PARTS-1) begin : g_last
      assign right_row = feed;
    end else begin : g_mid_r
      assign right_row = rows[g+1];
    end
    vpa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (IDX_W'(g)),
      .ctl       (ctl),
      .left      (left_row),
      .right     (right_row),
      .row       (rows[g]),
      .can_merge (merge_flags[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= CNT_W'(1);
      fit_mode  <= FIT_FIRST;
      out_valid <= 1'b0;
      step      <= '0;
      k         <= '0;
      found     <= 1'b0;
    end else begin
      // output register: loads a finished result, empties when taken
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (cfg_acc) begin
            if (cfg_index == REG_FIT_MODE) fit_mode <= cfg_data[1:0];
            else count <= CNT_W'(1);
          end
          if (in_acc) begin
            req   <= in_data;
            step  <= '0;
            found <= 1'b0;
            sum   <= '0;
            k     <= '0;
            if (in_data.owner_id == '0 ||
                (in_data.op == OP_ALLOC && in_data.request_size == '0)) begin
              res   <= '{status: ST_NOFIT, start_address: '0, freed_units: '0};
              state <= S_DONE;
            end else if (in_data.op == OP_ALLOC) begin
              res   <= '0;
              state <= S_SCAN;
            end else begin
              res   <= '0;
              state <= S_FREE;
            end
          end
        end

        S_SCAN: begin
          if (fits && (!found || better)) begin
            found      <= 1'b1;
            pick       <= step[IDX_W-1:0];
            pick_size  <= head.size;
            pick_start <= head.start;
          end
          step <= step + CNT_W'(1);
          if (step == CNT_W'(MAX_PARTS-1)) state <= S_APPLY;
        end

        S_APPLY: begin
          state <= S_DONE;
          if (!found) begin
            res.status <= ST_NOFIT;
          end else if (leftover != '0 && count == CNT_W'(MAX_PARTS)) begin
            res.status <= ST_FULL;
          end else begin
            res.status        <= ST_DONE;
            res.start_address <= pick_start;
            if (leftover != '0) count <= count + CNT_W'(1);
          end
        end

        S_FREE: begin
          if (owner_hit) sum <= sum + head.size;
          step <= step + CNT_W'(1);
          if (step == CNT_W'(MAX_PARTS-1)) state <= S_MERGE;
        end

        S_MERGE: begin
          if (merge_go) begin
            count <= count - CNT_W'(1);
          end else if (k_p1 < count) begin
            k <= k + IDX_W'(1);
          end else begin
            res.status      <= ST_DONE;
            res.freed_units <= sum;
            state           <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CNT_W'(MAX_PARTS)))
    else $error("row count out of range");

  a_split_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.cmd == CMD_SPLIT) |-> (count < CNT_W'(MAX_PARTS)))
    else $error("split issued on a full table");

  a_merge_bound: assert property (@(posedge clk) disable iff (rst)
    (ctl.cmd == CMD_MERGE) |-> (k_p1 < count))
    else $error("merge beyond the last row");

  a_pick_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && found) |-> (CNT_W'(pick) < count))
    else $error("picked row outside the table");
`endif

endmodule

>>> tb/tb_variable_partition_allocator_unit.sv
// testbench of the variable partition allocator: random and directed requests checked against a model
module tb_variable_partition_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import vpa_pkg::*;

  // table model plus queue of predicted results
  class alloc_scoreboard;
    logic [ADDR_W-1:0]     row_start [MAX_PARTS];
    logic [SIZE_W-1:0]     row_size  [MAX_PARTS];
    logic [OWNER_BITS-1:0] row_owner [MAX_PARTS];
    int                    rows;
    logic [1:0]            mode;
    out_t                  pending[$];
    int                    errors;
    int                    checked;
    int                    grants;
    int                    fulls;

    function void load_table(logic [8:0] units);
      int u;
      u = units;
      if (u == 0) u = 1;
      if (u > MEM_UNITS) u = MEM_UNITS;
      for (int i = 0; i < MAX_PARTS; i++) begin
        row_start[i] = '0;
        row_size[i] = '0;
        row_owner[i] = '0;
      end
      row_size[0] = SIZE_W'(u);
      rows = 1;
    endfunction

    function void write_reg(logic idx, logic [8:0] value);
      if (idx == REG_FIT_MODE) mode = value[1:0];
      else load_table(value);
    endfunction

    function out_t allocate(logic [OWNER_BITS-1:0] who, logic [SIZE_W-1:0] need);
      out_t r;
      int pick;
      int left;
      r = '0;
      r.status = ST_NOFIT;
      if (who == 0 || need == 0) return r;
      pick = rows;
      for (int i = 0; i < rows; i++) begin
        if (row_owner[i] != 0 || row_size[i] < need) continue;
        if (pick == rows) begin
          pick = i;
          if (mode != FIT_BEST && mode != FIT_WORST) break;
        end else if (mode == FIT_BEST && row_size[i] < row_size[pick]) begin
          pick = i;
        end else if (mode == FIT_WORST && row_size[i] > row_size[pick]) begin
          pick = i;
        end
      end
      if (pick >= rows) return r;
      left = row_size[pick] - need;
      if (left > 0) begin
        if (rows >= MAX_PARTS) begin
          r.status = ST_FULL;
          return r;
        end
        for (int i = rows; i > pick + 1; i--) begin
          row_start[i] = row_start[i-1];
          row_size[i] = row_size[i-1];
          row_owner[i] = row_owner[i-1];
        end
        row_start[pick+1] = ADDR_W'(row_start[pick] + need);
        row_size[pick+1] = SIZE_W'(left);
        row_owner[pick+1] = '0;
        rows++;
      end
      row_owner[pick] = who;
      row_size[pick] = need;
      r.status = ST_DONE;
      r.start_address = row_start[pick];
      return r;
    endfunction

    function out_t release_owner(logic [OWNER_BITS-1:0] who);
      out_t r;
      int keep;
      int sum;
      r = '0;
      keep = 0;
      sum = 0;
      if (who == 0) begin
        r.status = ST_NOFIT;
        return r;
      end
      for (int i = 0; i < rows; i++) begin
        if (row_owner[i] == who) begin
          row_owner[i] = '0;
          sum += row_size[i];
        end
        if (keep > 0 && row_owner[i] == 0 && row_owner[keep-1] == 0) begin
          row_size[keep-1] += row_size[i];
        end else begin
          row_start[keep] = row_start[i];
          row_size[keep] = row_size[i];
          row_owner[keep] = row_owner[i];
          keep++;
        end
      end
      for (int i = keep; i < MAX_PARTS; i++) begin
        row_start[i] = '0;
        row_size[i] = '0;
        row_owner[i] = '0;
      end
      rows = keep;
      r.status = ST_DONE;
      r.freed_units = SIZE_W'(sum);
      return r;
    endfunction

    function void note_request(in_t req);
      out_t r;
      if (req.op == OP_ALLOC) r = allocate(req.owner_id, req.request_size);
      else r = release_owner(req.owner_id);
      if (r.status == ST_DONE && req.op == OP_ALLOC) grants++;
      if (r.status == ST_FULL) fulls++;
      pending.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
        errors++;
      end
      if (got.start_address !== want.start_address) begin
        $display("%0t: start_address expected %0d actual %0d", $realtime,
                 want.start_address, got.start_address);
        errors++;
      end
      if (got.freed_units !== want.freed_units) begin
        $display("%0t: freed_units expected %0d actual %0d", $realtime,
                 want.freed_units, got.freed_units);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [8:0] cfg_data;

  alloc_scoreboard board;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_off;      // cycles left in a forced receiver hold-off
  int   cycle_count;
  int   sent;

  localparam int CYCLE_LIMIT = 3000000;

  variable_partition_allocator_unit dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    board = new();
    board.mode = FIT_FIRST;
    board.load_table(9'd256);
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FIT_MODE;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    cycle_count = 0;
    sent = 0;
  end

  // cycle counter and overall timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_variable_partition_allocator_unit: errors");
      $finish;
    end
  end

  // receiver: random stall, long hold-off when asked; checks each accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_result(out_data);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // one request transaction; valid drops only for a random gap before it
  task automatic send_request(logic op, logic [7:0] who, logic [8:0] need);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{op: op, owner_id: who, request_size: need};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(in_data);
    sent++;
  endtask

  // wait until every predicted result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // register write, only done with the block idle
  task automatic write_reg(logic idx, logic [8:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random sizes lean small so the table fills and splits often
  function automatic logic [8:0] pick_size(int units);
    int r;
    r = $urandom_range(99);
    if (r < 60) return 9'($urandom_range(8, 1));
    if (r < 85) return 9'($urandom_range(units > 1 ? units / 2 : 1, 1));
    if (r < 95) return 9'($urandom_range(511));
    return 9'd0;
  endfunction

  task automatic random_burst(int n, int units);
    logic [7:0] who;
    for (int i = 0; i < n; i++) begin
      who = (($urandom_range(99) < 3) ? 8'd0 : 8'($urandom_range(12, 1)));
      if ($urandom_range(99) < 3) who = 8'($urandom_range(255));
      if ($urandom_range(99) < 25) send_request(OP_FREE, who, 9'($urandom_range(511)));
      else send_request(OP_ALLOC, who, pick_size(units));
    end
  endtask

  initial begin
    int units;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: edges of fields, rejects, every fit mode, a full table
    send_request(OP_ALLOC, 8'd0, 9'd5);
    send_request(OP_ALLOC, 8'd1, 9'd0);
    send_request(OP_FREE, 8'd0, 9'd0);
    send_request(OP_ALLOC, 8'd255, 9'd511);
    send_request(OP_ALLOC, 8'd255, 9'd256);
    send_request(OP_FREE, 8'd255, 9'd256);
    send_request(OP_FREE, 8'd77, 9'd0);
    send_request(OP_ALLOC, 8'd1, 9'd10);
    send_request(OP_ALLOC, 8'd2, 9'd30);
    send_request(OP_ALLOC, 8'd3, 9'd5);
    send_request(OP_ALLOC, 8'd4, 9'd40);
    send_request(OP_FREE, 8'd2, 9'd0);
    send_request(OP_FREE, 8'd4, 9'd0);
    write_reg(REG_FIT_MODE, FIT_BEST);
    send_request(OP_ALLOC, 8'd5, 9'd4);
    write_reg(REG_FIT_MODE, FIT_WORST);
    send_request(OP_ALLOC, 8'd6, 9'd4);
    write_reg(REG_FIT_MODE, 9'd3);
    send_request(OP_ALLOC, 8'd7, 9'd4);
    // one-unit rows until the table is full, then a split is refused
    write_reg(REG_FIT_MODE, FIT_FIRST);
    write_reg(REG_TOTAL_UNITS, 9'd0);
    send_request(OP_ALLOC, 8'd9, 9'd2);
    write_reg(REG_TOTAL_UNITS, 9'd511);
    for (int i = 0; i < 63; i++) send_request(OP_ALLOC, 8'(i % 8 + 1), 9'd1);
    send_request(OP_ALLOC, 8'd128, 9'd1);
    send_request(OP_ALLOC, 8'd128, 9'd1);

    // random phases across idle mixes and register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      units = (ph == 0) ? 256 : ((ph == 5) ? 1 : $urandom_range(256, 2));
      if (ph == 7) units = 256;
      write_reg(REG_FIT_MODE, 9'($urandom_range(3)));
      write_reg(REG_TOTAL_UNITS, 9'(units));
      if (ph == 3) hold_off = 2000;  // receiver holds off, input backs up
      random_burst(150, units);
      if (ph == 4) drain();          // sender pauses until all results are in
    end

    drain();
    $display("covered %0d requests, %0d results, %0d grants, %0d table-full refusals",
             sent, board.checked, board.grants, board.fulls);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_variable_partition_allocator_unit: clean");
    end else begin
      $display("tb_variable_partition_allocator_unit: errors");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/vpa_pkg.sv
rtl/vpa_cell.sv
rtl/variable_partition_allocator_unit.sv
tb/tb_variable_partition_allocator_unit.sv
